### sv/fdkc_pkg.sv
// ----------------------------------------------------------------------------
// Keypad calculator package
// Widths, key codes, operation codes and the key map that the calculator
// core uses.
// ----------------------------------------------------------------------------
package fdkc_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int OpW         = $clog2(10 ** DIGIT_COUNT);
  localparam int ResW        = 2 * OpW;
  localparam int CntW        = $clog2(ResW + 1);
  localparam int BcdW        = 4 * DIGIT_COUNT;

  typedef logic [3:0] digit_t;
  typedef logic [6:0] key_t;
  typedef logic [2:0] op_t;

  localparam op_t OP_NONE = 3'd0;
  localparam op_t OP_ADD  = 3'd1;
  localparam op_t OP_SUB  = 3'd2;
  localparam op_t OP_MUL  = 3'd3;
  localparam op_t OP_DIV  = 3'd4;

  localparam key_t K_DIGIT_MAX = 7'd9;
  localparam key_t K_CLEAR     = 7'd101;
  localparam key_t K_ADD       = 7'd102;
  localparam key_t K_SUB       = 7'd103;
  localparam key_t K_MUL       = 7'd104;
  localparam key_t K_DIV       = 7'd105;
  localparam key_t K_EQ        = 7'd106;

  localparam key_t KEY_MAP [16] = '{
    7'd1, 7'd2, 7'd3, K_ADD,
    7'd4, 7'd5, 7'd6, K_SUB,
    7'd7, 7'd8, 7'd9, K_MUL,
    K_CLEAR, 7'd0, K_DIV, K_EQ
  };

  // Shift-add-3 correction for one BCD digit before it is doubled.
  function automatic digit_t add3(input digit_t d);
    digit_t r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

### sv/four_digit_keypad_calculator_core.sv
// ----------------------------------------------------------------------------
// Four digit keypad calculator core
// Takes one keypad poll per item, edits the decimal display, and computes
// add, subtract and multiply directly, and divide with a shared shift datapath.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake                  Payload
//   in       in_valid_i / in_ready_o    key_down_i, key_position_i
//   out      out_valid_o / out_ready_i  digit_*_o, negative_o, press_accepted_o
//
// Equals passes through ST_DIV for a division, then ST_SIGN, ST_CONV and
// ST_DONE: a bit-serial restoring divider and a shift-add-3 converter
// share one working shift register under the sequencer.
// in_ready_o is low while the sequencer is busy or the output register is full
// and not being taken. Reset zeroes the control, display and result state.
module four_digit_keypad_calculator_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             key_down_i,
  input  logic [3:0]       key_position_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fdkc_pkg::digit_t digit_ones_o,
  output fdkc_pkg::digit_t digit_tens_o,
  output fdkc_pkg::digit_t digit_hundreds_o,
  output fdkc_pkg::digit_t digit_thousands_o,
  output logic             negative_o,
  output logic             press_accepted_o
);
  import fdkc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_CONV = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]            state_q, state_d;
  digit_t                digits_q [DIGIT_COUNT];
  digit_t                digits_d [DIGIT_COUNT];
  logic [OpW-1:0]        first_q, first_d;
  op_t                   op_q, op_d;
  logic signed [ResW-1:0] res_q, res_d;
  logic                  was_pressed_q, was_pressed_d;
  logic                  neg_q, neg_d;
  logic [ResW-1:0]       work_q, work_d;
  logic [OpW-1:0]        rem_q, rem_d;
  logic [OpW-1:0]        div_q, div_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  digit_t                out_digits_q [DIGIT_COUNT];
  logic                  out_neg_q, out_acc_q, out_valid_q;
  logic                  load_out, acc_out;

  logic                  in_fire, out_free, press;
  key_t                  code;
  logic [OpW-1:0]        shown;
  logic [OpW:0]          trial;
  logic                  qbit;
  logic [OpW-1:0]        quot_next;
  logic [BcdW-1:0]       bcd_adj;
  logic [BcdW-1:0]       bcd_next;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign code       = KEY_MAP[key_position_i];
  assign press      = key_down_i && !was_pressed_q;

  // Display digits folded into a binary value, most significant digit first.
  always_comb begin
    shown = '0;
    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
      shown = OpW'(shown * OpW'(10)) + OpW'(digits_q[i]);
    end
  end

  // Restoring divider step.
  assign trial     = {rem_q, work_q[OpW-1]};
  assign qbit      = (trial >= {1'b0, div_q});
  assign quot_next = {work_q[OpW-2:0], qbit};

  // Shift-add-3 step; the carry out of the top digit is dropped, which keeps
  // only the low decimal digits of the magnitude.
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      bcd_adj[4*i +: 4] = add3(bcd_q[4*i +: 4]);
    end
  end
  assign bcd_next = {bcd_adj[BcdW-2:0], work_q[ResW-1]};

  always_comb begin
    state_d       = state_q;
    digits_d      = digits_q;
    first_d       = first_q;
    op_d          = op_q;
    res_d         = res_q;
    was_pressed_d = was_pressed_q;
    neg_d         = neg_q;
    work_d        = work_q;
    rem_d         = rem_q;
    div_d         = div_q;
    bcd_d         = bcd_q;
    cnt_d         = cnt_q;
    load_out      = 1'b0;
    acc_out       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          was_pressed_d = key_down_i;
          acc_out       = press;
          load_out      = 1'b1;
          if (press) begin
            if (code <= K_DIGIT_MAX) begin
              for (int i = DIGIT_COUNT - 1; i > 0; i--) begin
                digits_d[i] = digits_q[i-1];
              end
              digits_d[0] = code[3:0];
              neg_d       = 1'b0;
            end else if (code == K_CLEAR) begin
              for (int i = 0; i < DIGIT_COUNT; i++) begin
                digits_d[i] = '0;
              end
              first_d = '0;
              op_d    = OP_NONE;
              res_d   = '0;
              neg_d   = 1'b0;
            end else if (code >= K_ADD && code <= K_DIV) begin
              first_d = shown;
              op_d    = op_t'(code - K_ADD) + OP_ADD;
              for (int i = 0; i < DIGIT_COUNT; i++) begin
                digits_d[i] = '0;
              end
              neg_d = 1'b0;
            end else if (code == K_EQ) begin
              // The result item goes out when the sequencer finishes.
              load_out = 1'b0;
              div_d    = shown;
              state_d  = ST_SIGN;
              case (op_q)
                OP_ADD: res_d = ResW'(first_q) + ResW'(shown);
                OP_SUB: res_d = ResW'(first_q) - ResW'(shown);
                OP_MUL: res_d = ResW'(first_q) * ResW'(shown);
                OP_DIV: begin
                  // Division by zero keeps the previous result.
                  if (shown != '0) begin
                    work_d  = ResW'(first_q);
                    rem_d   = '0;
                    cnt_d   = '0;
                    state_d = ST_DIV;
                  end
                end
                default: res_d = '0;
              endcase
            end
          end
        end
      end
      ST_DIV: begin
        rem_d  = qbit ? OpW'(trial - {1'b0, div_q}) : trial[OpW-1:0];
        work_d = {work_q[ResW-1:OpW], quot_next};
        cnt_d  = cnt_q + CntW'(1);
        if (cnt_q == CntW'(OpW - 1)) begin
          res_d   = ResW'(quot_next);
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        neg_d   = res_q[ResW-1];
        work_d  = res_q[ResW-1] ? ResW'(-res_q) : ResW'(res_q);
        bcd_d   = '0;
        cnt_d   = '0;
        state_d = ST_CONV;
      end
      ST_CONV: begin
        bcd_d  = bcd_next;
        work_d = {work_q[ResW-2:0], 1'b0};
        cnt_d  = cnt_q + CntW'(1);
        if (cnt_q == CntW'(ResW - 1)) begin
          for (int i = 0; i < DIGIT_COUNT; i++) begin
            digits_d[i] = bcd_next[4*i +: 4];
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          acc_out  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digits_q[i] <= '0;
      end
      first_q       <= '0;
      op_q          <= OP_NONE;
      res_q         <= '0;
      was_pressed_q <= 1'b0;
      neg_q         <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      digits_q      <= digits_d;
      first_q       <= first_d;
      op_q          <= op_d;
      res_q         <= res_d;
      was_pressed_q <= was_pressed_d;
      neg_q         <= neg_d;
      cnt_q         <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    bcd_q  <= bcd_d;
    if (load_out) begin
      out_digits_q <= digits_d;
      out_neg_q    <= neg_d;
      out_acc_q    <= acc_out;
    end
  end

  digit_t dig_out [4];
  for (genvar g = 0; g < 4; g++) begin : g_dig
    if (g < DIGIT_COUNT) begin : g_on
      assign dig_out[g] = out_digits_q[g];
    end else begin : g_off
      assign dig_out[g] = '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign digit_ones_o      = dig_out[0];
  assign digit_tens_o      = dig_out[1];
  assign digit_hundreds_o  = dig_out[2];
  assign digit_thousands_o = dig_out[3];
  assign negative_o        = out_neg_q;
  assign press_accepted_o  = out_acc_q;

  // No new item while the sequencer is working on an equals press.
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o)
    else $error("input ready while sequencer busy");

  // The running remainder of the divider stays below the divisor.
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < div_q)
    else $error("divider remainder not below divisor");

  // The result is only ever offered after a full decimal conversion.
  a_done_after_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_DONE) |-> $past(state_q == ST_CONV))
    else $error("done state entered without conversion");

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_chk
    a_digit_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
      digits_q[g] <= 4'd9)
      else $error("display digit out of decimal range");
  end

endmodule
